/* design/qbw_pkg.sv */
// Shared types, constants and register codes for the quadratic B-spline waveform block
`timescale 1ns / 1ps
package qbw_pkg;

	localparam int DEF_MAX_SPLINES  = 64;
	localparam int DEF_MAX_CARRIERS = 4;

	localparam int VAL_W  = 40;
	localparam int TERM_W = 32;
	localparam int D2_W   = 45;

	localparam logic signed [63:0] VAL_MAX = 64'sd549755813887;
	localparam logic signed [63:0] VAL_MIN = -64'sd549755813888;

	localparam logic signed [31:0] RST_T_START  = 32'sd0;
	localparam logic signed [31:0] RST_T_STOP   = 32'sd0;
	localparam logic [30:0]        RST_SPACING  = 31'd65536;
	localparam logic [31:0]        RST_INV_W    = 32'd21845;
	localparam logic [6:0]         RST_SPLINES  = 7'd64;
	localparam logic [2:0]         RST_CARRIERS = 3'd1;

	typedef enum logic [2:0] {
		REG_T_START   = 3'd0,
		REG_T_STOP    = 3'd1,
		REG_SPACING   = 3'd2,
		REG_INV_WIDTH = 3'd3,
		REG_ZERO_BND  = 3'd4,
		REG_SPLINES   = 3'd5,
		REG_CARRIERS  = 3'd6
	} qbw_reg_t;

	typedef struct packed {
		logic [5:0]  en;
		logic        wr;
		logic [1:0]  carrier;
		logic [5:0]  idx;
		logic [31:0] coef;
		logic [32:0] rel;
		logic        zb;
	} qbw_lane_ctl_t;

endpackage

/* design/qbw_if.sv */
// Valid/ready channel interfaces for input items and result items
`timescale 1ns / 1ps
interface qbw_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [1:0]  carrier;
	logic [5:0]  spline_index;
	logic signed [31:0] coefficient;
	logic signed [31:0] time_point;

	modport source (output valid, op, carrier, spline_index, coefficient, time_point,
		input ready);
	modport sink (input valid, op, carrier, spline_index, coefficient, time_point,
		output ready);
endinterface

interface qbw_out_if;
	logic        valid;
	logic        ready;
	logic signed [39:0] value;
	logic        in_window;

	modport source (output valid, value, in_window, input ready);
	modport sink (input valid, value, in_window, output ready);
endinterface

/* design/qbw_lane.sv */
// One spline lane: coefficient storage, basis evaluation and weighted term
`timescale 1ns / 1ps
module qbw_lane import qbw_pkg::*; #(
	parameter int L            = 0,
	parameter int MAX_CARRIERS = DEF_MAX_CARRIERS,
	parameter int NW           = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  qbw_lane_ctl_t            ctl,
	input  logic [NW-1:0]            n_eff,
	input  logic [30:0]              ks,
	input  logic [31:0]              iw,
	output logic signed [TERM_W-1:0] term
);

	localparam int CW = (MAX_CARRIERS > 1) ? $clog2(MAX_CARRIERS) : 1;
	localparam logic signed [D2_W-1:0] KOFF = D2_W'(2 * L - 1);

	logic [31:0]             tab_q [MAX_CARRIERS];
	logic [MAX_CARRIERS-1:0] tval_q;
	logic [CW-1:0]           cidx;
	logic                    wr_hit;
	logic                    act;
	logic signed [D2_W-1:0]  off;
	logic signed [D2_W-1:0]  d2;
	logic [D2_W-1:0]         mag;
	logic [64:0]             prod;
	logic                    in_sup;
	logic [35:0]             six;
	logic                    half;
	logic [65:0]             sq;
	logic [66:0]             nine;
	logic [34:0]             q;
	logic [34:0]             bsel;
	logic signed [64:0]      cprod;

	logic [32:0]        mag_s2;
	logic               far_s2, neg_s2, act_s2;
	logic [31:0]        c_s2, c_s3, c_s4, c_s5, c_s6;
	logic [32:0]        tmag_s3;
	logic               neg_s3, in_s3;
	logic [32:0]        w_s4;
	logic               half_s4, in_s4;
	logic [62:0]        hs_s5;
	logic               half_s5, in_s5;
	logic [31:0]        b_s6;
	logic signed [TERM_W-1:0] term_s7;

	assign cidx   = CW'(ctl.carrier);
	assign wr_hit = ctl.wr && ({26'd0, ctl.idx} == L) && (int'(ctl.carrier) < MAX_CARRIERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tval_q <= '0;
		end else if (wr_hit) begin
			tval_q[cidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			tab_q[cidx] <= ctl.coef;
		end
	end

	assign act = (L < int'(n_eff)) &&
		!(ctl.zb && ((L <= 1) || (L + 2 >= int'(n_eff))));
	assign off = $signed({{(D2_W-31){1'b0}}, ks}) * KOFF;
	assign d2  = $signed({{(D2_W-33){1'b0}}, ctl.rel}) - off;
	assign mag = d2[D2_W-1] ? D2_W'(-d2) : D2_W'(d2);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			mag_s2 <= mag[32:0];
			far_s2 <= |mag[D2_W-1:33];
			neg_s2 <= d2[D2_W-1];
			act_s2 <= act;
			c_s2   <= ((int'(ctl.carrier) < MAX_CARRIERS) && tval_q[cidx]) ?
				tab_q[cidx] : 32'd0;
		end
	end

	assign prod   = {32'd0, mag_s2} * {33'd0, iw};
	assign in_sup = act_s2 && (!far_s2 || (iw == '0)) &&
		(neg_s2 ? (prod <= 65'h1_0000_0000) : (prod < 65'h1_0000_0000));

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			tmag_s3 <= prod[32:0];
			neg_s3  <= neg_s2;
			in_s3   <= in_sup;
			c_s3    <= c_s2;
		end
	end

	assign six  = {tmag_s3, 2'b00} + {1'b0, tmag_s3, 1'b0};
	assign half = neg_s3 ? (six > 36'h2_0000_0000) : (six >= 36'h2_0000_0000);

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			w_s4    <= half ? (33'h1_0000_0000 - tmag_s3) : tmag_s3;
			half_s4 <= half;
			in_s4   <= in_s3;
			c_s4    <= c_s3;
		end
	end

	assign sq = {33'd0, w_s4} * {33'd0, w_s4};

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			hs_s5   <= half_s4 ? sq[65:3] : sq[64:2];
			half_s5 <= half_s4;
			in_s5   <= in_s4;
			c_s5    <= c_s4;
		end
	end

	assign nine = {1'b0, hs_s5, 3'b000} + {4'd0, hs_s5};
	assign q    = nine[66:32];
	assign bsel = half_s5 ? q : (35'h0_C000_0000 - q);

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			b_s6 <= in_s5 ? bsel[31:0] : 32'd0;
			c_s6 <= c_s5;
		end
	end

	assign cprod = $signed({{33{c_s6[31]}}, c_s6}) * $signed({33'd0, b_s6});

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			term_s7 <= cprod[63:32];
		end
	end

	assign term = term_s7;

endmodule

/* design/qbw_tree.sv */
// Registered binary adder tree over the lane terms
`timescale 1ns / 1ps
module qbw_tree import qbw_pkg::*; #(
	parameter int N_IN = DEF_MAX_SPLINES,
	parameter int LVL  = $clog2(DEF_MAX_SPLINES),
	parameter int SW   = TERM_W + $clog2(DEF_MAX_SPLINES)
) (
	input  logic                     clk,
	input  logic [LVL-1:0]           en,
	input  logic signed [TERM_W-1:0] terms [N_IN],
	output logic signed [SW-1:0]     root
);

	localparam int NP = 2 ** LVL;

	logic signed [SW-1:0] leaf [NP];
	logic signed [SW-1:0] heap_q [1:NP-1];

	for (genvar i = 0; i < NP; i++) begin : g_leaf
		if (i < N_IN) begin : g_term
			assign leaf[i] = SW'(terms[i]);
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	for (genvar k = 1; k < NP; k++) begin : g_node
		localparam int D = $clog2(k + 1) - 1;
		if (2 * k >= NP) begin : g_bottom
			always_ff @(posedge clk) begin
				if (en[LVL-1-D]) begin
					heap_q[k] <= leaf[2*k-NP] + leaf[2*k+1-NP];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (en[LVL-1-D]) begin
					heap_q[k] <= heap_q[2*k] + heap_q[2*k+1];
				end
			end
		end
	end

	assign root = heap_q[1];

endmodule

/* design/quadratic_bspline_waveform.sv */
// Top level: configuration registers, pipeline control, lanes, adder tree, output stage
//
//  channel   dir  handshake            payload
//  in_ch     in   valid/ready          op, carrier, spline_index, coefficient, time_point
//  out_ch    out  valid/ready          value, in_window
//  cfg       in   cfg_we               cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ch.ready stays high. Stages in order:
// input stage, six lane stages, the adder tree levels, output register.
// Every stage holds its own valid bit; a stage loads when empty or when the next one
// advances, so bubbles close up under output backpressure.
// Reset clears all valid bits and loads configuration defaults; the table reads zero.
`timescale 1ns / 1ps
module quadratic_bspline_waveform import qbw_pkg::*; #(
	parameter int MAX_SPLINES  = DEF_MAX_SPLINES,
	parameter int MAX_CARRIERS = DEF_MAX_CARRIERS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	qbw_in_if.sink       in_ch,
	qbw_out_if.source    out_ch
);

	localparam int LVL = $clog2(MAX_SPLINES);
	localparam int SW  = TERM_W + LVL;
	localparam int NS  = 8 + LVL;
	localparam int NW  = $clog2(MAX_SPLINES + 1);

	logic signed [31:0] t_start_q, t_stop_q;
	logic [30:0]        spacing_q;
	logic [31:0]        inv_w_q;
	logic               zb_q;
	logic [6:0]         splines_q;
	logic [2:0]         carriers_q;

	logic [NW-1:0]      n_eff;
	logic [2:0]         nc_eff;
	logic               win;
	logic signed [32:0] diff;

	logic               vld_q [1:NS];
	logic               win_q [1:NS];
	logic               en    [1:NS+1];

	logic               op_s1;
	logic [1:0]         car_s1;
	logic [5:0]         idx_s1;
	logic [31:0]        coef_s1;
	logic [31:0]        diff_s1;

	qbw_lane_ctl_t            lctl;
	logic signed [TERM_W-1:0] terms [MAX_SPLINES];
	logic [LVL-1:0]           tree_en;
	logic signed [SW-1:0]     root;
	logic signed [63:0]       r64;
	logic signed [63:0]       sat;
	logic signed [VAL_W-1:0]  value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_start_q  <= RST_T_START;
			t_stop_q   <= RST_T_STOP;
			spacing_q  <= RST_SPACING;
			inv_w_q    <= RST_INV_W;
			zb_q       <= 1'b0;
			splines_q  <= RST_SPLINES;
			carriers_q <= RST_CARRIERS;
		end else if (cfg_we) begin
			case (qbw_reg_t'(cfg_index))
				REG_T_START:   t_start_q  <= cfg_data;
				REG_T_STOP:    t_stop_q   <= cfg_data;
				REG_SPACING:   spacing_q  <= cfg_data[30:0];
				REG_INV_WIDTH: inv_w_q    <= cfg_data;
				REG_ZERO_BND:  zb_q       <= cfg_data[0];
				REG_SPLINES:   splines_q  <= cfg_data[6:0];
				REG_CARRIERS:  carriers_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign n_eff  = (int'(splines_q) > MAX_SPLINES) ? NW'(MAX_SPLINES) : NW'(splines_q);
	assign nc_eff = (int'(carriers_q) > MAX_CARRIERS) ? 3'(MAX_CARRIERS) : carriers_q;
	assign diff   = 33'(in_ch.time_point) - 33'(t_start_q);
	assign win    = in_ch.op && ({1'b0, in_ch.carrier} < nc_eff) && (n_eff != '0) &&
		(in_ch.time_point >= t_start_q) && (in_ch.time_point <= t_stop_q);

	assign en[NS+1] = out_ch.ready;
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				vld_q[k] <= 1'b0;
				win_q[k] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_ch.valid;
				win_q[1] <= win;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
					win_q[k] <= win_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s1   <= in_ch.op;
			car_s1  <= in_ch.carrier;
			idx_s1  <= in_ch.spline_index;
			coef_s1 <= in_ch.coefficient;
			diff_s1 <= diff[31:0];
		end
	end

	assign in_ch.ready = en[1];

	always_comb begin
		lctl.en      = {en[7], en[6], en[5], en[4], en[3], en[2]};
		lctl.wr      = en[2] && vld_q[1] && !op_s1;
		lctl.carrier = car_s1;
		lctl.idx     = idx_s1;
		lctl.coef    = coef_s1;
		lctl.rel     = {diff_s1, 1'b0};
		lctl.zb      = zb_q;
	end

	for (genvar l = 0; l < MAX_SPLINES; l++) begin : g_lane
		qbw_lane #(
			.L            (l),
			.MAX_CARRIERS (MAX_CARRIERS),
			.NW           (NW)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lctl),
			.n_eff  (n_eff),
			.ks     (spacing_q),
			.iw     (inv_w_q),
			.term   (terms[l])
		);
	end

	for (genvar j = 0; j < LVL; j++) begin : g_tree_en
		assign tree_en[j] = en[8+j];
	end

	qbw_tree #(
		.N_IN (MAX_SPLINES),
		.LVL  (LVL),
		.SW   (SW)
	) u_tree (
		.clk   (clk),
		.en    (tree_en),
		.terms (terms),
		.root  (root)
	);

	assign r64 = 64'(root);
	assign sat = (r64 > VAL_MAX) ? VAL_MAX : ((r64 < VAL_MIN) ? VAL_MIN : r64);

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			value_q <= win_q[NS-1] ? sat[VAL_W-1:0] : '0;
		end
	end

	assign out_ch.valid     = vld_q[NS];
	assign out_ch.value     = value_q;
	assign out_ch.in_window = win_q[NS];

endmodule
